// ===== sv/pna_pkg.sv =====
`timescale 1ns / 1ps
package pna_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int COORD_W      = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W        = 40;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // One finished polygon on its way from the front end to the normaliser
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic                    overflow;
  } poly_sum_t;

  // Keep the low COORD_W bits and sign-extend them
  function automatic logic signed [15:0] sext_coord(input logic [15:0] v);
    logic signed [15:0] r;
    r = $signed(v << (16 - COORD_W));
    return r >>> (16 - COORD_W);
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] s);
    logic signed [SUM_W-1:0] r;
    if (s > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) begin
      r = SUM_MAX;
    end else if (s < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
      r = SUM_MIN;
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/vtx_if.sv =====
`timescale 1ns / 1ps
interface vtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic signed [15:0] vertex_z;
  logic               last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

// ===== sv/res_if.sv =====
`timescale 1ns / 1ps
interface res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [47:0]        half_area;
  logic               degenerate;
  logic               vertex_overflow;

  modport source (output valid, normal_x, normal_y, normal_z, half_area, degenerate,
                  vertex_overflow, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, half_area, degenerate,
                  vertex_overflow, output ready);
endinterface

// ===== sv/pna_front.sv =====
`timescale 1ns / 1ps
module pna_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  vtx_if.sink                 vtx_i,
  output pna_pkg::poly_sum_t  sum_o,
  output logic                push_o,
  input  logic                full_i
);
  import pna_pkg::*;

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_CLOSE = 3'd1;
  localparam logic [2:0] F_MUL   = 3'd2;
  localparam logic [2:0] F_ACC   = 3'd3;
  localparam logic [2:0] F_PUSH  = 3'd4;

  logic [2:0]              state_q;
  logic signed [15:0]      vin [3];
  logic signed [15:0]      first_q [3];
  logic signed [15:0]      prev_q [3];
  logic signed [15:0]      pa_q [3];
  logic signed [15:0]      pb_q [3];
  logic signed [31:0]      prod_q [6];
  logic signed [32:0]      term [3];
  logic signed [SUM_W-1:0] sum_q [3];
  logic [CNT_W-1:0]        cnt_q;
  logic                    ovf_q;
  logic                    last_q;
  logic                    close_q;

  assign vin[0] = sext_coord(vtx_i.vertex_x);
  assign vin[1] = sext_coord(vtx_i.vertex_y);
  assign vin[2] = sext_coord(vtx_i.vertex_z);

  assign vtx_i.ready = (state_q == F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !full_i;
  assign sum_o       = '{sum_x: sum_q[0], sum_y: sum_q[1], sum_z: sum_q[2], overflow: ovf_q};

  assign term[0] = 33'(prod_q[0]) - 33'(prod_q[1]);
  assign term[1] = 33'(prod_q[2]) - 33'(prod_q[3]);
  assign term[2] = 33'(prod_q[4]) - 33'(prod_q[5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      close_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k]   <= '0;
        first_q[k] <= '0;
        prev_q[k]  <= '0;
      end
    end else begin
      case (state_q)
        F_IDLE: begin
          if (vtx_i.valid) begin
            last_q  <= vtx_i.last_vertex;
            close_q <= 1'b0;
            if (cnt_q == '0) begin
              first_q <= vin;
              prev_q  <= vin;
              cnt_q   <= CNT_W'(1);
              state_q <= vtx_i.last_vertex ? F_CLOSE : F_IDLE;
            end else if (cnt_q < CNT_W'(MAX_VERTICES)) begin
              pa_q    <= prev_q;
              pb_q    <= vin;
              prev_q  <= vin;
              cnt_q   <= cnt_q + CNT_W'(1);
              state_q <= F_MUL;
            end else begin
              // drop the word, remember it happened
              ovf_q   <= 1'b1;
              state_q <= vtx_i.last_vertex ? F_CLOSE : F_IDLE;
            end
          end
        end
        F_CLOSE: begin
          pa_q    <= prev_q;
          pb_q    <= first_q;
          close_q <= 1'b1;
          state_q <= F_MUL;
        end
        F_MUL: begin
          prod_q[0] <= pa_q[1] * pb_q[2];
          prod_q[1] <= pa_q[2] * pb_q[1];
          prod_q[2] <= pa_q[2] * pb_q[0];
          prod_q[3] <= pa_q[0] * pb_q[2];
          prod_q[4] <= pa_q[0] * pb_q[1];
          prod_q[5] <= pa_q[1] * pb_q[0];
          state_q   <= F_ACC;
        end
        F_ACC: begin
          for (int k = 0; k < 3; k++) begin
            sum_q[k] <= sat_sum((SUM_W+1)'(sum_q[k]) + (SUM_W+1)'(term[k]));
          end
          if (close_q) begin
            state_q <= F_PUSH;
          end else begin
            state_q <= last_q ? F_CLOSE : F_IDLE;
          end
        end
        F_PUSH: begin
          if (!full_i) begin
            for (int k = 0; k < 3; k++) begin
              sum_q[k] <= '0;
            end
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/pna_fifo.sv =====
`timescale 1ns / 1ps
module pna_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pna_pkg::poly_sum_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output pna_pkg::poly_sum_t data_o
);
  import pna_pkg::*;

  poly_sum_t  mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== sv/pna_back.sv =====
`timescale 1ns / 1ps
module pna_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pna_pkg::poly_sum_t data_i,
  output logic               pop_o,
  res_if.source              res_o
);
  import pna_pkg::*;

  localparam int NW = 115;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_SQ    = 3'd1;
  localparam logic [2:0] B_SUM   = 3'd2;
  localparam logic [2:0] B_SQRT  = 3'd3;
  localparam logic [2:0] B_NINIT = 3'd4;
  localparam logic [2:0] B_NORM  = 3'd5;
  localparam logic [2:0] B_OUT   = 3'd6;

  logic [2:0]           state_q;
  logic signed [SUM_W-1:0] cs [3];
  logic [39:0]          mg_q [3];
  logic                 neg_q [3];
  logic [79:0]          sq_q [3];
  logic [79:0]          q_q;
  logic                 degen_q;
  logic                 ovf_q;
  logic [1:0]           k_q;
  logic [1:0]           part_q;
  logic [39:0]          half_q;
  logic [39:0]          hbit_q;
  logic [79:0]          hsq_q;
  logic [79:0]          hsh_q;
  logic [79:0]          pw_q;
  logic signed [NW-1:0] y_q;
  logic signed [NW-1:0] xs_q;
  logic signed [NW-1:0] qs_q;
  logic signed [NW-1:0] rhs_q;
  logic [14:0]          m_q;
  logic [14:0]          mbit_q;
  logic [15:0]          nrm_q [3];

  logic [39:0]          mg_cur;
  logic [19:0]          mul_a;
  logic [19:0]          mul_b;
  logic [39:0]          mul_p;
  logic [79:0]          sq_add;
  logic [79:0]          sq_cand;
  logic [79:0]          q4;
  logic signed [NW-1:0] y_cand;
  logic                 n_take;
  logic [14:0]          m_next;

  assign cs[0] = data_i.sum_x;
  assign cs[1] = data_i.sum_y;
  assign cs[2] = data_i.sum_z;

  assign pop_o = (state_q == B_IDLE) && valid_i;

  // One 20x20 partial product of a squared magnitude per cycle
  assign mg_cur = mg_q[k_q];
  assign mul_a  = (part_q == 2'd0) ? mg_cur[19:0] : mg_cur[39:20];
  assign mul_b  = (part_q == 2'd2) ? mg_cur[39:20] : mg_cur[19:0];
  assign mul_p  = mul_a * mul_b;
  always_comb begin
    case (part_q)
      2'd0:    sq_add = 80'(mul_p);
      2'd1:    sq_add = 80'(mul_p) << 21;
      default: sq_add = 80'(mul_p) << 40;
    endcase
  end

  assign q4      = {2'b00, q_q[79:2]};
  assign sq_cand = hsq_q + hsh_q + pw_q;

  // (2m-1)^2 * q for the trial bit, tracked by shifts and adds
  assign y_cand = y_q + xs_q + qs_q;
  assign n_take = (y_cand <= rhs_q);
  assign m_next = n_take ? (m_q | mbit_q) : m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      res_o.valid <= 1'b0;
      k_q       <= '0;
      part_q    <= '0;
    end else begin
      // drop the word once taken, unless a new one replaces it
      if (res_o.valid && res_o.ready && (state_q != B_OUT)) begin
        res_o.valid <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (valid_i) begin
            for (int k = 0; k < 3; k++) begin
              mg_q[k]  <= cs[k][SUM_W-1] ? 40'(-cs[k]) : 40'(cs[k]);
              neg_q[k] <= cs[k][SUM_W-1];
              sq_q[k]  <= '0;
            end
            degen_q <= (cs[0] == '0) && (cs[1] == '0) && (cs[2] == '0);
            ovf_q   <= data_i.overflow;
            k_q     <= 2'd0;
            part_q  <= 2'd0;
            state_q <= B_SQ;
          end
        end
        B_SQ: begin
          sq_q[k_q] <= sq_q[k_q] + sq_add;
          if (part_q == 2'd2) begin
            part_q <= 2'd0;
            if (k_q == 2'd2) begin
              state_q <= B_SUM;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end else begin
            part_q <= part_q + 2'd1;
          end
        end
        B_SUM: begin
          q_q     <= sq_q[0] + sq_q[1] + sq_q[2];
          half_q  <= '0;
          hsq_q   <= '0;
          hsh_q   <= '0;
          pw_q    <= 80'(1) << 78;
          hbit_q  <= 40'(1) << 39;
          state_q <= B_SQRT;
        end
        B_SQRT: begin
          if (sq_cand <= q4) begin
            hsq_q  <= sq_cand;
            half_q <= half_q | hbit_q;
            hsh_q  <= (hsh_q + (pw_q << 1)) >> 1;
          end else begin
            hsh_q  <= hsh_q >> 1;
          end
          pw_q   <= pw_q >> 2;
          hbit_q <= hbit_q >> 1;
          if (hbit_q[0]) begin
            k_q     <= 2'd0;
            state_q <= B_NINIT;
          end
        end
        B_NINIT: begin
          rhs_q  <= NW'(sq_q[k_q]) <<< 30;
          y_q    <= NW'(q_q);
          xs_q   <= -(NW'(q_q) <<< 16);
          qs_q   <= NW'(q_q) <<< 30;
          m_q    <= '0;
          mbit_q <= 15'(1) << 14;
          if (degen_q) begin
            nrm_q[k_q] <= '0;
            if (k_q == 2'd2) begin
              state_q <= B_OUT;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end else begin
            state_q <= B_NORM;
          end
        end
        B_NORM: begin
          if (n_take) begin
            y_q  <= y_cand;
            xs_q <= (xs_q + (qs_q <<< 1)) >>> 1;
          end else begin
            xs_q <= xs_q >>> 1;
          end
          qs_q   <= qs_q >>> 2;
          m_q    <= m_next;
          mbit_q <= mbit_q >> 1;
          if (mbit_q[0]) begin
            nrm_q[k_q] <= neg_q[k_q] ? -16'(m_next) : 16'(m_next);
            if (k_q == 2'd2) begin
              state_q <= B_OUT;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= B_NINIT;
            end
          end
        end
        B_OUT: begin
          if (!res_o.valid || res_o.ready) begin
            res_o.valid           <= 1'b1;
            res_o.normal_x        <= nrm_q[0];
            res_o.normal_y        <= nrm_q[1];
            res_o.normal_z        <= nrm_q[2];
            res_o.half_area       <= {8'd0, half_q};
            res_o.degenerate      <= degen_q;
            res_o.vertex_overflow <= ovf_q;
            state_q               <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/polygon_normal_area.sv =====
`timescale 1ns / 1ps
// Front end: a vertex passes accept, multiply and accumulate (the first: accept only);
// the last adds close, multiply, accumulate for the closing term and a push held while the
// queue is full. No vertex is taken until the last is accumulated; the normaliser takes
// one polygon at a time (9 squaring, 40 root steps, then the normal steps of each axis).
// Reset: asynchronous, active low; clears polygon state, the queue and the output valid flag.
module polygon_normal_area (
  input  logic clk_i,
  input  logic rst_ni,
  vtx_if.sink   vtx_i,
  res_if.source res_o
);
  import pna_pkg::*;

  poly_sum_t push_data;
  poly_sum_t pop_data;
  logic      push;
  logic      full;
  logic      pop;
  logic      avail;

  pna_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_i),
    .sum_o  (push_data),
    .push_o (push),
    .full_i (full)
  );

  pna_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (avail),
    .data_o  (pop_data)
  );

  pna_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (avail),
    .data_i  (pop_data),
    .pop_o   (pop),
    .res_o   (res_o)
  );

  a_degen_zero_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.degenerate |->
      res_o.normal_x == 16'sd0 && res_o.normal_y == 16'sd0 && res_o.normal_z == 16'sd0)
    else $error("degenerate result with nonzero normal");

  a_degen_zero_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.degenerate |-> res_o.half_area == 48'd0)
    else $error("degenerate result with nonzero area");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.normal_x >= -16'sd16384 && res_o.normal_x <= 16'sd16384)
    else $error("normal x out of unit range");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import pna_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        last;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [47:0]        area;
    logic               degen;
    logic               ovf;
  } poly_result_t;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vtx_if vtx();
  res_if res();

  polygon_normal_area dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx),
    .res_o  (res)
  );

  always #5 clk_i = ~clk_i;

  vertex_t      pending_vertices[$];
  poly_result_t expected_results[$];
  int           errors = 0;
  int           results_seen = 0;
  int           items_sent = 0;

  // polygon state of the predictor
  logic signed [15:0] poly_first[3];
  logic signed [15:0] poly_prev[3];
  longint             poly_sum[3];
  int                 poly_count = 0;
  bit                 poly_ovf = 1'b0;

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [15:0] coord_of(input logic [15:0] v);
    logic signed [15:0] r;
    r = $signed(v << (16 - COORD_W));
    return r >>> (16 - COORD_W);
  endfunction

  function automatic void sum_cross(input logic signed [15:0] p[3],
                                    input logic signed [15:0] c[3]);
    longint t[3];
    longint s;
    t[0] = longint'(p[1]) * c[2] - longint'(p[2]) * c[1];
    t[1] = longint'(p[2]) * c[0] - longint'(p[0]) * c[2];
    t[2] = longint'(p[0]) * c[1] - longint'(p[1]) * c[0];
    for (int k = 0; k < 3; k++) begin
      s = poly_sum[k] + t[k];
      if (s > 64'sd549755813887) s = 64'sd549755813887;
      if (s < -64'sd549755813888) s = -64'sd549755813888;
      poly_sum[k] = s;
    end
  endfunction

  function automatic logic [63:0] mag64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // nearest Q1.14 value of s / sqrt(q), ties away from zero
  function automatic logic [15:0] unit_component(input logic [63:0] s, input logic [127:0] q);
    logic [127:0] a2;
    logic [127:0] rhs;
    logic [127:0] c;
    logic [127:0] m;
    logic [127:0] t;
    a2 = 128'(s << 15);
    rhs = a2 * a2;
    m = 0;
    for (int b = 14; b >= 0; b--) begin
      t = m | (128'd1 << b);
      c = (2 * t - 1) * (2 * t - 1);
      if (c * q <= rhs) m = t;
    end
    return m[15:0];
  endfunction

  function automatic void clear_polygon();
    for (int k = 0; k < 3; k++) begin
      poly_first[k] = '0;
      poly_prev[k] = '0;
      poly_sum[k] = 0;
    end
    poly_count = 0;
    poly_ovf = 1'b0;
  endfunction

  function automatic void predict_vertex(input vertex_t w);
    logic signed [15:0] v[3];
    logic [127:0] q;
    logic [127:0] q4;
    logic [127:0] t;
    logic [127:0] half;
    logic [15:0]  n[3];
    logic [63:0]  m;
    poly_result_t r;
    v[0] = coord_of(w.x);
    v[1] = coord_of(w.y);
    v[2] = coord_of(w.z);
    if (poly_count == 0) begin
      poly_first = v;
      poly_prev = v;
      poly_count = 1;
    end else if (poly_count < MAX_VERTICES) begin
      sum_cross(poly_prev, v);
      poly_prev = v;
      poly_count++;
    end else begin
      poly_ovf = 1'b1;
    end
    if (!w.last) return;
    sum_cross(poly_prev, poly_first);
    q = 0;
    for (int k = 0; k < 3; k++) begin
      m = mag64(poly_sum[k]);
      q += 128'(m) * 128'(m);
    end
    q4 = q >> 2;
    half = 0;
    for (int k = 47; k >= 0; k--) begin
      t = half | (128'd1 << k);
      if (t * t <= q4) half = t;
    end
    for (int k = 0; k < 3; k++) begin
      n[k] = '0;
      if (q != 0) begin
        n[k] = unit_component(mag64(poly_sum[k]), q);
        if (poly_sum[k] < 0) n[k] = -n[k];
      end
    end
    r.nx = n[0];
    r.ny = n[1];
    r.nz = n[2];
    r.area = half[47:0];
    r.degen = (q == 0);
    r.ovf = poly_ovf;
    expected_results.push_back(r);
    clear_polygon();
  endfunction

  // driver
  int send_gap = 0;
  bit send_burst = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx.valid <= 1'b0;
      vtx.vertex_x <= '0;
      vtx.vertex_y <= '0;
      vtx.vertex_z <= '0;
      vtx.last_vertex <= 1'b0;
    end else begin
      if (vtx.valid && vtx.ready) begin
        predict_vertex({vtx.vertex_x, vtx.vertex_y, vtx.vertex_z, vtx.last_vertex});
        items_sent++;
        if (items_sent % 200 == 0) send_burst = ~send_burst;
      end
      if (vtx.valid && !vtx.ready) begin
        // hold the word until taken
      end else if (send_gap > 0) begin
        send_gap--;
        vtx.valid <= 1'b0;
      end else if (pending_vertices.size() > 0) begin
        vertex_t w;
        w = pending_vertices.pop_front();
        vtx.valid <= 1'b1;
        vtx.vertex_x <= w.x;
        vtx.vertex_y <= w.y;
        vtx.vertex_z <= w.z;
        vtx.last_vertex <= w.last;
        send_gap = send_burst ? 0 : $urandom_range(0, 13);
      end else begin
        vtx.valid <= 1'b0;
      end
    end
  end

  // monitor
  int recv_gap = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        poly_result_t want;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (res.normal_x !== want.nx) report_mismatch("normal_x", res.normal_x, want.nx);
          if (res.normal_y !== want.ny) report_mismatch("normal_y", res.normal_y, want.ny);
          if (res.normal_z !== want.nz) report_mismatch("normal_z", res.normal_z, want.nz);
          if (res.half_area !== want.area)
            report_mismatch("half_area", res.half_area, want.area);
          if (res.degenerate !== want.degen)
            report_mismatch("degenerate", res.degenerate, want.degen);
          if (res.vertex_overflow !== want.ovf)
            report_mismatch("vertex_overflow", res.vertex_overflow, want.ovf);
        end
        results_seen++;
        if (results_seen == 12 && !held_once) begin
          held_once = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        recv_gap = (results_seen % 60 < 20) ? 0 : $urandom_range(0, 13);
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted word
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [15:0] pick_coord(input int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 511) - 256);
      default: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  task automatic add_vertex(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input logic last);
    vertex_t w;
    w.x = x;
    w.y = y;
    w.z = z;
    w.last = last;
    pending_vertices.push_back(w);
  endtask

  // kind: 0 full range, 1 small, 2 extremes, 3 one repeated point, 4 flat in z
  task automatic add_polygon(input int n, input int kind);
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] flat_z;
    x = pick_coord(0);
    y = pick_coord(0);
    flat_z = pick_coord(0);
    for (int i = 0; i < n; i++) begin
      if (kind == 3) begin
        z = flat_z;
      end else if (kind == 4) begin
        x = pick_coord(0);
        y = pick_coord(0);
        z = flat_z;
      end else begin
        x = pick_coord(kind);
        y = pick_coord(kind);
        z = pick_coord(kind);
      end
      add_vertex(x, y, z, i == n - 1);
    end
  endtask

  initial begin
    int n;
    int kind;
    int total;
    clear_polygon();

    // single vertex and two-vertex polygons: zero sum
    add_vertex(16'h7fff, 16'h8000, 16'h1234, 1'b1);
    add_vertex(16'h0100, 16'h0000, 16'h0000, 1'b0);
    add_vertex(16'h0000, 16'h0100, 16'h0000, 1'b1);
    // a right triangle and an equilateral triangle at the coordinate extremes
    add_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_vertex(16'h7fff, 16'h0000, 16'h0000, 1'b0);
    add_vertex(16'h0000, 16'h7fff, 16'h0000, 1'b1);
    add_vertex(16'h8000, 16'h8000, 16'h8000, 1'b0);
    add_vertex(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
    add_vertex(16'h8000, 16'h7fff, 16'h7fff, 1'b1);
    // collinear points
    add_vertex(16'h0100, 16'h0200, 16'h0300, 1'b0);
    add_vertex(16'h0200, 16'h0400, 16'h0600, 1'b0);
    add_vertex(16'hff00, 16'hfe00, 16'hfd00, 1'b1);
    // unit square in the yz plane, wound negatively
    add_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0100, 1'b0);
    add_vertex(16'h0000, 16'h0100, 16'h0100, 1'b0);
    add_vertex(16'h0000, 16'h0100, 16'h0000, 1'b1);
    // all ones and all zeros
    add_vertex(16'hffff, 16'hffff, 16'hffff, 1'b0);
    add_vertex(16'h0000, 16'hffff, 16'h0000, 1'b0);
    add_vertex(16'hffff, 16'h0000, 16'h0000, 1'b1);
    total = pending_vertices.size();

    while (total < 1500) begin
      case ($urandom_range(0, 19))
        0: n = $urandom_range(1, 2);
        1: n = $urandom_range(MAX_VERTICES - 2, MAX_VERTICES + 6);
        default: n = $urandom_range(3, 8);
      endcase
      kind = $urandom_range(0, 9);
      if (kind > 4) kind = kind % 2;
      add_polygon(n, kind);
      total += n;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_vertices.size() == 0 && !vtx.valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/pna_pkg.sv
sv/vtx_if.sv
sv/res_if.sv
sv/pna_front.sv
sv/pna_fifo.sv
sv/pna_back.sv
sv/polygon_normal_area.sv
verif/tb_top.sv
